FILE: sv/lli_pkg.sv
// Shared widths, constants and the queue entry type of the line intersection block.
`default_nettype none
package lli_pkg;

    // Coordinate width of every input and result point.
    localparam int CB = 16;
    // Width of a coordinate difference.
    localparam int DW = CB + 1;
    // Width of a cross product.
    localparam int XW = 2 * DW + 1;
    // Width of the product of a difference magnitude and a cross product magnitude.
    localparam int PW = DW + XW;
    // Width of the signed sum of a base point and a quotient.
    localparam int SW = 43;
    // Width used to compare the rounded quotient against its limit.
    localparam int QW = (PW + 1 > 41) ? PW + 1 : 41;
    // A rounded quotient above this bound saturates at once.
    localparam logic [QW-1:0] QLIM = QW'(1) << 40;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic signed [XW-1:0] num;
        logic signed [XW-1:0] den;
        logic signed [DW-1:0] d1x;
        logic signed [DW-1:0] d1y;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } t_qent;

endpackage
`default_nettype wire

FILE: sv/line_line_intersection.sv
// Top level of the line intersection block: front, queue and back.
//
//  Port group   Dir  Payload
//  s_axis       in   tdata: p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y (16 bits each)
//  m_axis       out  tdata: cross_x, cross_y; tuser: is_parallel, clipped
//
// One beat per cycle is taken and delivered in steady state while m_axis does not stall.
// The path runs through two front stages, the queue, one multiply stage,
// 52 restoring division stages (one quotient bit each) and the output register.
// Reset clears all valid bits and the queue; payload registers are not reset.
// When m_axis stalls, the back pipeline holds and the queue fills; s_axis_tready
// falls once the queue and the front stages together hold four items.
`default_nettype none
module line_line_intersection (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // p_x, p_y, q_x, q_y, r_x, r_y, s_x, s_y from the lowest bit up
    input  wire logic [8*lli_pkg::CB-1:0]  s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // cross_x, cross_y from the lowest bit up
    output logic [2*lli_pkg::CB-1:0]       m_axis_tdata,
    // is_parallel, clipped from the lowest bit up
    output logic [1:0]                     m_axis_tuser
);

    logic                      w_push, w_pop, w_empty;
    lli_pkg::t_qent            w_ent_in, w_ent_out;
    logic [lli_pkg::QAW:0]     w_level;

    lli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_level (w_level),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_ent   (w_ent_in)
    );

    lli_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_ent_in),
        .i_pop   (w_pop),
        .o_ent   (w_ent_out),
        .o_empty (w_empty),
        .o_level (w_level)
    );

    lli_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_ent    (w_ent_out),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (w_level != (lli_pkg::QAW+1)'(lli_pkg::QDEPTH)))
        else $error("queue overflow");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue underflow");

    // A parallel result is the origin and never clipped.
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("parallel result not zero");

endmodule
`default_nettype wire

FILE: sv/lli_front.sv
// Front part: takes beats, forms differences and cross products, and feeds the queue.
`default_nettype none
module lli_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [8*lli_pkg::CB-1:0]      i_data,
    input  wire logic [lli_pkg::QAW:0]         i_level,
    output logic                               o_ready,
    output logic                               o_push,
    output lli_pkg::t_qent                     o_ent
);

    localparam int CB  = lli_pkg::CB;
    localparam int DW  = lli_pkg::DW;
    localparam int XW  = lli_pkg::XW;
    localparam int QAW = lli_pkg::QAW;

    logic signed [CB-1:0] w_px, w_py, w_qx, w_qy, w_rx, w_ry, w_sx, w_sy;

    // Stage one: differences.
    logic                 r_v1;
    logic signed [DW-1:0] r_d1x, r_d1y, r_d2x, r_d2y, r_xx, r_xy;
    logic signed [CB-1:0] r_px1, r_py1;

    // Stage two: the four partial cross products.
    logic                   r_v2;
    logic signed [2*DW-1:0] r_a, r_b, r_c, r_e;
    logic signed [DW-1:0]   r_d1x2, r_d1y2;
    logic signed [CB-1:0]   r_px2, r_py2;

    logic [QAW+1:0] w_use;

    // Unpack the beat, first field in the lowest bits.
    assign w_px = i_data[0*CB +: CB];
    assign w_py = i_data[1*CB +: CB];
    assign w_qx = i_data[2*CB +: CB];
    assign w_qy = i_data[3*CB +: CB];
    assign w_rx = i_data[4*CB +: CB];
    assign w_ry = i_data[5*CB +: CB];
    assign w_sx = i_data[6*CB +: CB];
    assign w_sy = i_data[7*CB +: CB];

    // A beat is taken only if the queue has room for it and all items in flight here.
    assign w_use   = (QAW+2)'(i_level) + (QAW+2)'(r_v1) + (QAW+2)'(r_v2);
    assign o_ready = w_use < (QAW+2)'(lli_pkg::QDEPTH);

    // Valid bits of the two stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid && o_ready;
            r_v2 <= r_v1;
        end
    end

    // Payload of the two stages.
    always_ff @(posedge i_clk) begin
        r_d1x  <= DW'(w_qx) - DW'(w_px);
        r_d1y  <= DW'(w_qy) - DW'(w_py);
        r_d2x  <= DW'(w_sx) - DW'(w_rx);
        r_d2y  <= DW'(w_sy) - DW'(w_ry);
        r_xx   <= DW'(w_rx) - DW'(w_px);
        r_xy   <= DW'(w_ry) - DW'(w_py);
        r_px1  <= w_px;
        r_py1  <= w_py;
        r_a    <= (2*DW)'(r_xx) * (2*DW)'(r_d2y);
        r_b    <= (2*DW)'(r_xy) * (2*DW)'(r_d2x);
        r_c    <= (2*DW)'(r_d1x) * (2*DW)'(r_d2y);
        r_e    <= (2*DW)'(r_d1y) * (2*DW)'(r_d2x);
        r_d1x2 <= r_d1x;
        r_d1y2 <= r_d1y;
        r_px2  <= r_px1;
        r_py2  <= r_py1;
    end

    // Finish the cross products on the way into the queue.
    always_comb begin
        o_push    = r_v2;
        o_ent.num = XW'(r_a) - XW'(r_b);
        o_ent.den = XW'(r_c) - XW'(r_e);
        o_ent.d1x = r_d1x2;
        o_ent.d1y = r_d1y2;
        o_ent.px  = r_px2;
        o_ent.py  = r_py2;
    end

endmodule
`default_nettype wire

FILE: sv/lli_fifo.sv
// Short queue that decouples the front from the back.
`default_nettype none
module lli_fifo (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire lli_pkg::t_qent        i_ent,
    input  wire logic                  i_pop,
    output lli_pkg::t_qent             o_ent,
    output logic                       o_empty,
    output logic [lli_pkg::QAW:0]      o_level
);

    localparam int QAW = lli_pkg::QAW;

    lli_pkg::t_qent r_mem [lli_pkg::QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(i_push) - (QAW+1)'(i_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    assign o_ent   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_level = r_cnt;

endmodule
`default_nettype wire

FILE: sv/lli_back.sv
// Back part: multiply, pipelined restoring division, rounding and saturation.
`default_nettype none
module lli_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire lli_pkg::t_qent            i_ent,
    output logic                           o_pop,
    output logic                           o_tvalid,
    input  wire logic                      i_tready,
    output logic [2*lli_pkg::CB-1:0]       o_tdata,
    output logic [1:0]                     o_tuser
);

    localparam int CB = lli_pkg::CB;
    localparam int DW = lli_pkg::DW;
    localparam int XW = lli_pkg::XW;
    localparam int PW = lli_pkg::PW;
    localparam int SW = lli_pkg::SW;
    localparam int QW = lli_pkg::QW;

    // One stage of the division pipeline, both axes side by side.
    typedef struct packed {
        logic [XW-1:0]        rem_x;
        logic [XW-1:0]        rem_y;
        logic [PW-1:0]        dv_x;
        logic [PW-1:0]        dv_y;
        logic [XW-1:0]        dm;
        logic                 neg_x;
        logic                 neg_y;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 par;
    } t_dst;

    t_dst r_st [PW+1];
    t_dst n_st [PW+1];
    logic r_sv [PW+1];

    logic                 w_en;
    logic [XW-1:0]        w_mnum, w_mden;
    logic [DW-1:0]        w_mdx, w_mdy;
    logic [CB:0]          w_fx, w_fy;

    logic                 r_ov;
    logic signed [CB-1:0] r_cx, r_cy;
    logic                 r_par, r_clip;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    function automatic logic [XW+PW-1:0] dstep(input logic [XW-1:0] rem,
                                               input logic [PW-1:0] dv,
                                               input logic [XW-1:0] dm);
        logic [XW:0] t;
        logic        ge;
        t  = {rem, dv[PW-1]};
        ge = (t >= {1'b0, dm});
        if (ge) begin
            t = t - {1'b0, dm};
        end
        return {t[XW-1:0], dv[PW-2:0], ge};
    endfunction

    // Round half to even, add to the base point and saturate; returns {clip, coord}.
    function automatic logic [CB:0] finish(input logic [PW-1:0] q,
                                           input logic [XW-1:0] rem,
                                           input logic [XW-1:0] dm,
                                           input logic neg,
                                           input logic signed [CB-1:0] p);
        logic [XW:0]          tw;
        logic                 up;
        logic [PW:0]          ql;
        logic signed [CB-1:0] cmin;
        logic signed [CB-1:0] cmax;
        logic signed [SW-1:0] mq;
        logic signed [SW-1:0] s;
        tw   = {rem, 1'b0};
        up   = (tw > {1'b0, dm}) || ((tw == {1'b0, dm}) && q[0]);
        ql   = (PW+1)'(q) + (PW+1)'(up);
        cmin = {1'b1, {(CB-1){1'b0}}};
        cmax = {1'b0, {(CB-1){1'b1}}};
        mq   = $signed(SW'(ql));
        s    = SW'(p) + (neg ? -mq : mq);
        if (QW'(ql) > lli_pkg::QLIM) begin
            return {1'b1, (neg ? cmin : cmax)};
        end else if (s < SW'(cmin)) begin
            return {1'b1, cmin};
        end else if (s > SW'(cmax)) begin
            return {1'b1, cmax};
        end
        return {1'b0, s[CB-1:0]};
    endfunction

    // The whole back advances together while the output register can move.
    assign w_en  = !r_ov || i_tready;
    assign o_pop = w_en && i_valid;

    // Magnitudes of the operands.
    assign w_mnum = i_ent.num[XW-1] ? XW'(-i_ent.num) : XW'(i_ent.num);
    assign w_mden = i_ent.den[XW-1] ? XW'(-i_ent.den) : XW'(i_ent.den);
    assign w_mdx  = i_ent.d1x[DW-1] ? DW'(-i_ent.d1x) : DW'(i_ent.d1x);
    assign w_mdy  = i_ent.d1y[DW-1] ? DW'(-i_ent.d1y) : DW'(i_ent.d1y);

    // Next values of every pipeline stage.
    always_comb begin
        n_st[0].rem_x = '0;
        n_st[0].rem_y = '0;
        n_st[0].dv_x  = PW'(w_mdx) * PW'(w_mnum);
        n_st[0].dv_y  = PW'(w_mdy) * PW'(w_mnum);
        n_st[0].dm    = w_mden;
        n_st[0].neg_x = i_ent.d1x[DW-1] ^ i_ent.num[XW-1] ^ i_ent.den[XW-1];
        n_st[0].neg_y = i_ent.d1y[DW-1] ^ i_ent.num[XW-1] ^ i_ent.den[XW-1];
        n_st[0].px    = i_ent.px;
        n_st[0].py    = i_ent.py;
        n_st[0].par   = (i_ent.den == '0);
        for (int k = 0; k < PW; k++) begin
            n_st[k+1] = r_st[k];
            {n_st[k+1].rem_x, n_st[k+1].dv_x} = dstep(r_st[k].rem_x, r_st[k].dv_x,
                                                      r_st[k].dm);
            {n_st[k+1].rem_y, n_st[k+1].dv_y} = dstep(r_st[k].rem_y, r_st[k].dv_y,
                                                      r_st[k].dm);
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= PW; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_sv[0] <= i_valid;
            for (int k = 0; k < PW; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k <= PW; k++) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Final rounding of both axes.
    assign w_fx = finish(r_st[PW].dv_x, r_st[PW].rem_x, r_st[PW].dm,
                         r_st[PW].neg_x, r_st[PW].px);
    assign w_fy = finish(r_st[PW].dv_y, r_st[PW].rem_y, r_st[PW].dm,
                         r_st[PW].neg_y, r_st[PW].py);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_sv[PW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_st[PW].par) begin
                r_cx   <= '0;
                r_cy   <= '0;
                r_par  <= 1'b1;
                r_clip <= 1'b0;
            end else begin
                r_cx   <= w_fx[CB-1:0];
                r_cy   <= w_fy[CB-1:0];
                r_par  <= 1'b0;
                r_clip <= w_fx[CB] | w_fy[CB];
            end
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {r_cy, r_cx};
    assign o_tuser  = {r_clip, r_par};

endmodule
`default_nettype wire
